>>> src/comment_skipping_comma_tokenizer_assert.svh
// Assertion macros for the comment skipping comma tokenizer.
// Used by the top level only; needs a clock and an active high reset.
`ifndef COMMENT_SKIPPING_COMMA_TOKENIZER_ASSERT_SVH
`define COMMENT_SKIPPING_COMMA_TOKENIZER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define CSKT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// Check that cons holds in the cycle after ante.
`define CSKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

>>> src/cskt_pkg.sv
// Shared types and constants of the comment skipping comma tokenizer.
// No dependencies; imported by every module of the block but cskt_ram.
`default_nettype none

package cskt_pkg;

   // Token buffer slots and run descriptors
   localparam int SLOT_W   = 3;
   localparam int NSLOTS   = 1 << SLOT_W;
   localparam int LEN_W    = 6;
   localparam int MAX_RUN  = 32;
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = 2;
   localparam int QCNT_W   = 3;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   typedef enum logic [2:0] {
      MODE_SKIP,
      MODE_AFTER_QUOTE,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_BLOCK_STAR,
      MODE_QUOTE,
      MODE_WORD
   } mode_type;

   // One finished token: where its bytes sit and how many to send
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0]  len;
      logic              empty;
   } desc_type;

   // Up to two finished tokens per word from the front
   typedef struct packed {
      logic     vld0;
      desc_type d0;
      logic     vld1;
      desc_type d1;
   } push_type;

   // One result word
   typedef struct packed {
      logic [7:0] token_byte;
      logic       token_last;
      logic       token_empty;
   } result_type;

endpackage

`default_nettype wire

>>> src/comment_skipping_comma_tokenizer.sv
// Comment skipping comma tokenizer: top level with the register port.
// Depends on cskt_pkg, cskt_front, cskt_queue, cskt_back, cskt_ram.
//
// Usage:
//   Text enters one byte per word on the req_ queue port (push/full); byte
//   0 or end_of_text closes the text. Tokens leave on the rsp_ queue port
//   (empty/pop), one byte per word, token_last on the final byte and
//   token_empty on the single marker of an empty token.
//   Register swallow_comma (address 0, reset 1) is written over csr_.
// Timing:
//   The front takes one text byte per cycle while full is low. A token's
//   first byte passes the descriptor queue, the token and read registers
//   and the result queue; the back then reads one byte per cycle from the
//   buffer while the receiver keeps up, after loading each token. full
//   rises while the descriptor queue (4 deep) has fewer than two free
//   entries, so the input stalls only when tokens pile up behind a slow
//   receiver. A stalled receiver holds the oldest word on the rsp_ ports.
// Reset:
//   Clears scan state, queues and pointers; swallow_comma returns to 1.
//   The token buffer is not cleared and needs no clearing pass.
`default_nettype none

module comment_skipping_comma_tokenizer #(
   parameter int TOKEN_MAX = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_end_of_text,
   input  wire logic        req_push,
   output logic             req_full,
   // result channel
   output logic [7:0]       rsp_token_byte,
   output logic             rsp_token_last,
   output logic             rsp_token_empty,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   import cskt_pkg::*;

   `include "comment_skipping_comma_tokenizer_assert.svh"

   localparam int IW = $clog2(TOKEN_MAX);
   localparam int AW = SLOT_W + IW;

   logic              swallow_ff, swallow_in;
   logic              accept;
   push_type          push;
   desc_type          q_head;
   logic              q_nonempty, q_pop;
   logic [QCNT_W-1:0] q_count;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {31'd0, swallow_ff} : 32'd0;

   always_comb begin
      swallow_in = swallow_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0)) begin
         swallow_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swallow_ff <= 1'b1;
      end else begin
         swallow_ff <= swallow_in;
      end
   end

   // Leave room for two descriptors from one text byte
   assign req_full = (q_count > QCNT_W'(QDEPTH - 2));
   assign accept   = req_push && !req_full;

   cskt_front #(
      .TOKEN_MAX (TOKEN_MAX)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .text_byte     (req_text_byte),
      .end_of_text   (req_end_of_text),
      .swallow_comma (swallow_ff),
      .push          (push),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data)
   );

   cskt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (q_pop),
      .head     (q_head),
      .nonempty (q_nonempty),
      .count    (q_count)
   );

   cskt_ram #(
      .WIDTH (8),
      .DEPTH (NSLOTS << IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cskt_back #(
      .TOKEN_MAX (TOKEN_MAX)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .q_nonempty      (q_nonempty),
      .q_pop           (q_pop),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .rsp_token_byte  (rsp_token_byte),
      .rsp_token_last  (rsp_token_last),
      .rsp_token_empty (rsp_token_empty),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop)
   );

   // Empty marker is a single zero word that ends its token
   `CSKT_ASSERT_IMPLY(a_empty_marker, clock, reset, !rsp_empty && rsp_token_empty, rsp_token_last && (rsp_token_byte == 8'd0))
   // Back only takes a descriptor that is there
   `CSKT_ASSERT_IMPLY(a_pop_nonempty, clock, reset, q_pop, q_count != '0)
   // Accepted text never overruns the descriptor queue
   `CSKT_ASSERT_NEXT(a_queue_bound, clock, reset, accept, q_count <= QCNT_W'(QDEPTH))

endmodule

`default_nettype wire

>>> src/cskt_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none

module cskt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/cskt_front.sv
// Front of the tokenizer: classifies each text word, tracks the scan mode,
// writes token bytes into the slot buffer and hands finished tokens on.
// Depends on cskt_pkg.
`default_nettype none

module cskt_front #(
   parameter int TOKEN_MAX = 32
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         accept,
   input  wire logic [7:0]                                   text_byte,
   input  wire logic                                         end_of_text,
   input  wire logic                                         swallow_comma,
   output cskt_pkg::push_type                                push,
   output logic                                              wr_en,
   output logic [cskt_pkg::SLOT_W+$clog2(TOKEN_MAX)-1:0]     wr_addr,
   output logic [7:0]                                        wr_data
);

   import cskt_pkg::*;

   localparam int IW = $clog2(TOKEN_MAX);
   localparam int CW = $clog2(TOKEN_MAX + 1);

   mode_type          mode_ff, mode_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic              is_word_ch, is_comma, is_nul, closing;
   logic              start_tok, do_word;
   logic              feed_emit, close_emit;
   logic [CW-1:0]     feed_len, close_len;
   logic [IW-1:0]     wr_idx;
   logic [SLOT_W-1:0] wr_slot;

   // Clip a run length to what one item may send
   function automatic logic [LEN_W-1:0] clip_run(input logic [CW-1:0] raw);
      logic [6:0] wide;
      wide = 7'(raw);
      if (wide > 7'(MAX_RUN)) begin
         clip_run = LEN_W'(MAX_RUN);
      end else begin
         clip_run = LEN_W'(wide);
      end
   endfunction

   assign is_nul     = (text_byte == CH_NUL);
   assign is_comma   = (text_byte == CH_COMMA);
   assign is_word_ch = (text_byte > CH_SPACE) && !is_comma;
   assign closing    = is_nul || end_of_text;
   assign start_tok  = (mode_ff == MODE_SKIP) ||
                       ((mode_ff == MODE_AFTER_QUOTE) && !(is_comma && swallow_comma));
   assign do_word    = (mode_ff == MODE_WORD) ||
                       ((mode_ff == MODE_SLASH) && (text_byte != CH_SLASH) &&
                        (text_byte != CH_STAR));

   // Scan one word of text, then close the text if it ends here
   always_comb begin
      mode_in    = mode_ff;
      cnt_in     = cnt_ff;
      wr_en      = 1'b0;
      wr_idx     = '0;
      feed_emit  = 1'b0;
      feed_len   = '0;
      close_emit = 1'b0;
      close_len  = '0;
      if (accept) begin
         if (!is_nul) begin
            if (start_tok) begin
               if (text_byte <= CH_SPACE) begin
                  mode_in = MODE_SKIP;
               end else if (text_byte == CH_SLASH) begin
                  // park the slash at the slot start in case it opens a word
                  wr_en   = 1'b1;
                  cnt_in  = CW'(1);
                  mode_in = MODE_SLASH;
               end else if (text_byte == CH_QUOTE) begin
                  cnt_in  = '0;
                  mode_in = MODE_QUOTE;
               end else begin
                  wr_en   = 1'b1;
                  cnt_in  = CW'(1);
                  mode_in = MODE_WORD;
               end
            end else if (do_word) begin
               if (is_word_ch) begin
                  mode_in = MODE_WORD;
                  if (cnt_ff < CW'(TOKEN_MAX)) begin
                     wr_en  = 1'b1;
                     wr_idx = cnt_ff[IW-1:0];
                     cnt_in = cnt_ff + CW'(1);
                  end
               end else begin
                  feed_emit = 1'b1;
                  feed_len  = (cnt_ff >= CW'(TOKEN_MAX)) ? '0 : cnt_ff;
                  if (is_comma && !swallow_comma) begin
                     // the comma opens the next word in the next slot
                     wr_en   = 1'b1;
                     cnt_in  = CW'(1);
                     mode_in = MODE_WORD;
                  end else begin
                     mode_in = MODE_SKIP;
                  end
               end
            end else begin
               case (mode_ff)
                  MODE_AFTER_QUOTE: begin
                     mode_in = MODE_SKIP;
                  end
                  MODE_SLASH: begin
                     mode_in = (text_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK_STAR;
                  end
                  MODE_LINE: begin
                     if (text_byte == CH_NL) begin
                        mode_in = MODE_SKIP;
                     end
                  end
                  MODE_BLOCK: begin
                     if (text_byte == CH_STAR) begin
                        mode_in = MODE_BLOCK_STAR;
                     end
                  end
                  MODE_BLOCK_STAR: begin
                     if (text_byte == CH_SLASH) begin
                        mode_in = MODE_SKIP;
                     end else if (text_byte != CH_STAR) begin
                        mode_in = MODE_BLOCK;
                     end
                  end
                  MODE_QUOTE: begin
                     if (text_byte == CH_QUOTE) begin
                        feed_emit = 1'b1;
                        feed_len  = cnt_ff;
                        mode_in   = MODE_AFTER_QUOTE;
                     end else if (cnt_ff < CW'(TOKEN_MAX - 1)) begin
                        wr_en  = 1'b1;
                        wr_idx = cnt_ff[IW-1:0];
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  default: begin
                     mode_in = MODE_SKIP;
                  end
               endcase
            end
         end
         if (closing) begin
            case (mode_in)
               MODE_WORD: begin
                  close_emit = 1'b1;
                  close_len  = (cnt_in >= CW'(TOKEN_MAX)) ? '0 : cnt_in;
               end
               MODE_QUOTE: begin
                  close_emit = 1'b1;
                  close_len  = cnt_in;
               end
               MODE_SLASH: begin
                  close_emit = 1'b1;
                  close_len  = CW'(1);
               end
               default: begin
                  close_emit = 1'b0;
               end
            endcase
            mode_in = MODE_SKIP;
            cnt_in  = '0;
         end
      end
   end

   // Each finished token takes its slot with it
   always_comb begin
      wr_slot       = slot_ff + SLOT_W'(feed_emit);
      slot_in       = slot_ff + SLOT_W'(feed_emit) + SLOT_W'(close_emit);
      push.vld0     = feed_emit;
      push.d0.slot  = slot_ff;
      push.d0.len   = clip_run(feed_len);
      push.d0.empty = (feed_len == '0);
      push.vld1     = close_emit;
      push.d1.slot  = wr_slot;
      push.d1.len   = clip_run(close_len);
      push.d1.empty = (close_len == '0);
      wr_addr       = {wr_slot, wr_idx};
      wr_data       = text_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SKIP;
         cnt_ff  <= '0;
         slot_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         slot_ff <= slot_in;
      end
   end

endmodule

`default_nettype wire

>>> src/cskt_queue.sv
// Short queue of finished token descriptors between front and back.
// Takes up to two descriptors per cycle, gives one. Depends on cskt_pkg.
`default_nettype none

module cskt_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cskt_pkg::push_type            push,
   input  wire logic                          pop,
   output cskt_pkg::desc_type                 head,
   output logic                               nonempty,
   output logic [cskt_pkg::QCNT_W-1:0]        count
);

   import cskt_pkg::*;

   desc_type          mem_ff [QDEPTH];
   desc_type          mem_in [QDEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in, wptr_nx;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]        n_push;

   assign n_push = 2'(push.vld0) + 2'(push.vld1);
   assign wptr_nx = wptr_ff + QPTR_W'(1);

   // Write the valid descriptors in order at the tail
   always_comb begin
      for (int i = 0; i < QDEPTH; i++) begin
         mem_in[i] = mem_ff[i];
         if (push.vld0 && (wptr_ff == QPTR_W'(i))) begin
            mem_in[i] = push.d0;
         end
         if (push.vld1 && !push.vld0 && (wptr_ff == QPTR_W'(i))) begin
            mem_in[i] = push.d1;
         end
         if (push.vld1 && push.vld0 && (wptr_nx == QPTR_W'(i))) begin
            mem_in[i] = push.d1;
         end
      end
      wptr_in = wptr_ff + QPTR_W'(n_push);
      rptr_in = rptr_ff + QPTR_W'(pop);
      cnt_in  = cnt_ff + QCNT_W'(n_push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         mem_ff[i] <= mem_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign head     = mem_ff[rptr_ff];
   assign nonempty = (cnt_ff != '0);
   assign count    = cnt_ff;

endmodule

`default_nettype wire

>>> src/cskt_back.sv
// Back of the tokenizer: takes descriptors, reads token bytes from the
// slot buffer and queues result words. Depends on cskt_pkg.
`default_nettype none

module cskt_back #(
   parameter int TOKEN_MAX = 32
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire cskt_pkg::desc_type                           head,
   input  wire logic                                         q_nonempty,
   output logic                                              q_pop,
   output logic                                              rd_en,
   output logic [cskt_pkg::SLOT_W+$clog2(TOKEN_MAX)-1:0]     rd_addr,
   input  wire logic [7:0]                                   rd_data,
   output logic [7:0]                                        rsp_token_byte,
   output logic                                              rsp_token_last,
   output logic                                              rsp_token_empty,
   output logic                                              rsp_empty,
   input  wire logic                                         rsp_pop
);

   import cskt_pkg::*;

   localparam int IW = $clog2(TOKEN_MAX);

   logic          busy_ff, busy_in;
   desc_type      cur_ff, cur_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          rd_last_ff, rd_last_in;
   logic          rd_empty_ff, rd_empty_in;

   result_type    oq_ff [2];
   result_type    oq_in [2];
   result_type    oq_new;
   logic          oq_head_ff, oq_head_in;
   logic          oq_tail_ff, oq_tail_in;
   logic [1:0]    oq_cnt_ff, oq_cnt_in;

   logic          pop_fire, load, issue, is_last;
   logic [2:0]    occ;

   // Step through the current token, one byte read per cycle with room
   always_comb begin
      pop_fire    = rsp_pop && (oq_cnt_ff != 2'd0);
      occ         = 3'(oq_cnt_ff) + 3'(rd_vld_ff) - 3'(pop_fire);
      issue       = busy_ff && (occ < 3'd2);
      load        = !busy_ff && q_nonempty;
      is_last     = cur_ff.empty || ((7'(idx_ff) + 7'd1) == 7'(cur_ff.len));
      q_pop       = load;
      cur_in      = load ? head : cur_ff;
      busy_in     = busy_ff;
      idx_in      = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (issue) begin
         idx_in = idx_ff + IW'(1);
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      rd_vld_in   = issue;
      rd_last_in  = is_last;
      rd_empty_in = cur_ff.empty;
      rd_en       = issue && !cur_ff.empty;
      rd_addr     = {cur_ff.slot, idx_ff};
   end

   // Hold finished words until the receiver takes them
   always_comb begin
      oq_new.token_byte  = rd_empty_ff ? 8'd0 : rd_data;
      oq_new.token_last  = rd_last_ff;
      oq_new.token_empty = rd_empty_ff;
      oq_in[0] = oq_ff[0];
      oq_in[1] = oq_ff[1];
      if (rd_vld_ff) begin
         oq_in[oq_tail_ff] = oq_new;
      end
      oq_tail_in = oq_tail_ff ^ rd_vld_ff;
      oq_head_in = oq_head_ff ^ pop_fire;
      oq_cnt_in  = oq_cnt_ff + 2'(rd_vld_ff) - 2'(pop_fire);
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      rd_last_ff  <= rd_last_in;
      rd_empty_ff <= rd_empty_in;
      oq_ff[0]    <= oq_in[0];
      oq_ff[1]    <= oq_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         rd_vld_ff  <= 1'b0;
         oq_head_ff <= 1'b0;
         oq_tail_ff <= 1'b0;
         oq_cnt_ff  <= 2'd0;
      end else begin
         busy_ff    <= busy_in;
         rd_vld_ff  <= rd_vld_in;
         oq_head_ff <= oq_head_in;
         oq_tail_ff <= oq_tail_in;
         oq_cnt_ff  <= oq_cnt_in;
      end
   end

   assign rsp_token_byte  = oq_ff[oq_head_ff].token_byte;
   assign rsp_token_last  = oq_ff[oq_head_ff].token_last;
   assign rsp_token_empty = oq_ff[oq_head_ff].token_empty;
   assign rsp_empty       = (oq_cnt_ff == 2'd0);

endmodule

`default_nettype wire
